FILE: rtl/stack_expression_evaluator_unit_assert.svh
// Assertion macros for the stack expression evaluator.
`ifndef STACK_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH
`define STACK_EXPRESSION_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define SEV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define SEV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sev_pkg.sv
// Package: constants, codes and shared types of the stack expression evaluator.
`timescale 1ns / 1ps
`default_nettype none

package sev_pkg;

  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned DEPTH_W     = 4;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned STEP_W      = $clog2(DATA_W);

  // operator codes; anything above OP_POW drops two entries
  typedef enum logic [CODE_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_DIV = 3'd2,
    OP_MUL = 3'd3,
    OP_POW = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNDER = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    A_IDLE,
    A_DIV,
    A_FIX,
    A_PMUL,
    A_PSQ,
    A_DONE
  } alu_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } alu_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/stack_expression_evaluator_unit.sv
// Stack expression evaluator top level: stack memory, sequencer, output register.
// Ready returns with the output word.
// Push, underflow, full-drop: one word per cycle while the output register is free;
// divide steps through 32 quotient bits plus a sign fix, or finishes at once on a zero
// divisor; power multiplies and squares per exponent bit, or finishes at once for a zero or negative exponent.
// Async active-low reset empties the stack; stack contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "stack_expression_evaluator_unit_assert.svh"

module stack_expression_evaluator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              mode_i,
  input  wire logic signed [sev_pkg::DATA_W-1:0] operand_value_i,
  input  wire logic [sev_pkg::CODE_W-1:0]        operator_code_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [sev_pkg::DATA_W-1:0]      top_value_o,
  output logic [sev_pkg::DEPTH_W-1:0]            depth_o,
  output logic [sev_pkg::STATUS_W-1:0]           status_o
);

  localparam int unsigned W   = sev_pkg::DATA_W;
  localparam int unsigned CW  = sev_pkg::CNT_W;
  localparam int unsigned IW  = sev_pkg::IDX_W;
  localparam int unsigned DW  = sev_pkg::DEPTH_W;

  sev_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [W-1:0]     top_q, top_d;
  sev_pkg::status_e sts_q, sts_d;
  logic [sev_pkg::CODE_W-1:0] code_q, code_d;

  logic             out_valid_q, out_valid_d;
  logic [W-1:0]     out_top_q;
  logic [DW-1:0]    out_depth_q;
  sev_pkg::status_e out_sts_q;

  logic [W-1:0]     mem_q [sev_pkg::STACK_DEPTH];
  logic [W-1:0]     rd_q;
  logic             mem_we;
  logic [IW-1:0]    mem_wa;
  logic [W-1:0]     mem_wd;
  logic [IW-1:0]    rd_addr;

  logic [CW-1:0]    cnt_m1, cnt_m2, cnt_m3;
  logic [CW+DW-1:0] cnt_ext;
  logic             slot_free;
  logic             load_out;
  logic             drop_in;

  sev_pkg::alu_req_t alu_req;
  sev_pkg::alu_rsp_t alu_rsp;
  logic [W-1:0]      alu_res;

  sev_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .lhs_i    (top_q),
    .rhs_i    (rd_q),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  assign cnt_m1    = cnt_q - CW'(1);
  assign cnt_m2    = cnt_q - CW'(2);
  assign cnt_m3    = cnt_q - CW'(3);
  assign drop_in   = (operator_code_i > sev_pkg::CODE_W'(sev_pkg::OP_POW));
  // right operand sits below the top; a drop-two needs the entry under both
  assign rd_addr   = drop_in ? cnt_m3[IW-1:0] : cnt_m2[IW-1:0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == sev_pkg::S_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    top_d         = top_q;
    sts_d         = sts_q;
    code_d        = code_q;
    mem_we        = 1'b0;
    mem_wa        = cnt_q[IW-1:0];
    mem_wd        = operand_value_i;
    alu_req.start = 1'b0;
    alu_req.op    = sev_pkg::op_e'(code_q);
    load_out      = 1'b0;
    case (state_q)
      sev_pkg::S_IDLE: begin
        if (in_valid_i) begin
          code_d = operator_code_i;
          if (!mode_i) begin
            if (cnt_q >= CW'(sev_pkg::STACK_DEPTH)) begin
              sts_d = sev_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CW'(1);
              top_d  = operand_value_i;
              sts_d  = sev_pkg::ST_OK;
            end
          end else if (cnt_q < CW'(2)) begin
            sts_d = sev_pkg::ST_UNDER;
          end
          if (mode_i && cnt_q >= CW'(2)) begin
            state_d = sev_pkg::S_START;
          end else if (slot_free) begin
            load_out = 1'b1;
          end else begin
            state_d = sev_pkg::S_EMIT;
          end
        end
      end
      sev_pkg::S_START: begin
        case (sev_pkg::op_e'(code_q))
          sev_pkg::OP_ADD, sev_pkg::OP_SUB, sev_pkg::OP_DIV,
          sev_pkg::OP_MUL, sev_pkg::OP_POW: begin
            alu_req.start = 1'b1;
            state_d       = sev_pkg::S_WAIT;
          end
          default: begin
            cnt_d   = cnt_m2;
            top_d   = rd_q;
            sts_d   = sev_pkg::ST_OK;
            state_d = sev_pkg::S_EMIT;
          end
        endcase
      end
      sev_pkg::S_WAIT: begin
        if (alu_rsp.done) begin
          mem_we  = 1'b1;
          mem_wa  = cnt_m2[IW-1:0];
          mem_wd  = alu_res;
          cnt_d   = cnt_m1;
          top_d   = alu_res;
          sts_d   = alu_rsp.div_zero ? sev_pkg::ST_DIVZ : sev_pkg::ST_OK;
          state_d = sev_pkg::S_EMIT;
        end
      end
      sev_pkg::S_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = sev_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sev_pkg::S_IDLE;
      end
    endcase
  end

  assign cnt_ext = {DW'(0), cnt_d};

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sev_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    sts_q  <= sts_d;
    code_q <= code_d;
    if (load_out) begin
      out_top_q   <= (cnt_d == '0) ? '0 : top_d;
      out_depth_q <= cnt_ext[DW-1:0];
      out_sts_q   <= sts_d;
    end
  end

  // stack storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign status_o    = out_sts_q;

  `SEV_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(sev_pkg::STACK_DEPTH), "stack count overflow")
  `SEV_ASSERT_NEXT(a_push_grows, in_valid_i && in_ready_o && !mode_i && cnt_q < CW'(sev_pkg::STACK_DEPTH), cnt_q == $past(cnt_q) + CW'(1), "push did not grow stack")
  `SEV_ASSERT_NOW(a_divz_zero, out_valid_o && status_o == sev_pkg::STATUS_W'(sev_pkg::ST_DIVZ), top_value_o == '0, "divide by zero word with nonzero top")
  `SEV_ASSERT_NOW(a_empty_zero, out_valid_o && depth_o == '0, top_value_o == '0, "empty stack word with nonzero top")

endmodule

`default_nettype wire

FILE: rtl/sev_alu.sv
// Shared iterative arithmetic unit: add, sub, one multiplier, restoring divider, power.
`timescale 1ns / 1ps
`default_nettype none

module sev_alu (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sev_pkg::alu_req_t             req_i,
  input  wire logic [sev_pkg::DATA_W-1:0]    lhs_i,
  input  wire logic [sev_pkg::DATA_W-1:0]    rhs_i,
  output sev_pkg::alu_rsp_t                  rsp_o,
  output logic [sev_pkg::DATA_W-1:0]         result_o
);

  localparam int unsigned W = sev_pkg::DATA_W;

  sev_pkg::alu_state_e state_q, state_d;

  // acc: result / quotient / power accumulator; aux: divisor / running square
  logic [W-1:0]      acc_q, acc_d;
  logic [W-1:0]      aux_q, aux_d;
  logic [W-1:0]      rem_q, rem_d;
  logic [W-2:0]      exp_q, exp_d;
  logic [sev_pkg::STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic              divz_q, divz_d;

  logic [W-1:0]      mul_a, mul_b;
  logic [2*W-1:0]    mul_full;
  logic [W-1:0]      prod;
  logic [W:0]        div_sh, div_diff;

  assign mul_full = mul_a * mul_b;
  assign prod     = mul_full[W-1:0];

  assign div_sh   = {rem_q, acc_q[W-1]};
  assign div_diff = div_sh - {1'b0, aux_q};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    aux_d   = aux_q;
    rem_d   = rem_q;
    exp_d   = exp_q;
    step_d  = step_q;
    neg_d   = neg_q;
    divz_d  = divz_q;
    mul_a   = acc_q;
    mul_b   = aux_q;
    case (state_q)
      sev_pkg::A_IDLE: begin
        if (req_i.start) begin
          divz_d = 1'b0;
          case (req_i.op)
            sev_pkg::OP_ADD: begin
              acc_d   = lhs_i + rhs_i;
              state_d = sev_pkg::A_DONE;
            end
            sev_pkg::OP_SUB: begin
              acc_d   = lhs_i - rhs_i;
              state_d = sev_pkg::A_DONE;
            end
            sev_pkg::OP_MUL: begin
              mul_a   = lhs_i;
              mul_b   = rhs_i;
              acc_d   = prod;
              state_d = sev_pkg::A_DONE;
            end
            sev_pkg::OP_DIV: begin
              if (rhs_i == '0) begin
                acc_d   = '0;
                divz_d  = 1'b1;
                state_d = sev_pkg::A_DONE;
              end else begin
                acc_d   = lhs_i[W-1] ? (W'(0) - lhs_i) : lhs_i;
                aux_d   = rhs_i[W-1] ? (W'(0) - rhs_i) : rhs_i;
                rem_d   = '0;
                neg_d   = lhs_i[W-1] ^ rhs_i[W-1];
                step_d  = '1;
                state_d = sev_pkg::A_DIV;
              end
            end
            sev_pkg::OP_POW: begin
              if (rhs_i[W-1]) begin
                // negative exponent: only bases 1 and -1 survive
                if (lhs_i == W'(1)) begin
                  acc_d = W'(1);
                end else if (lhs_i == '1) begin
                  acc_d = rhs_i[0] ? '1 : W'(1);
                end else begin
                  acc_d = '0;
                end
                state_d = sev_pkg::A_DONE;
              end else if (rhs_i == '0) begin
                acc_d   = W'(1);
                state_d = sev_pkg::A_DONE;
              end else begin
                acc_d   = W'(1);
                aux_d   = lhs_i;
                exp_d   = rhs_i[W-2:0];
                state_d = sev_pkg::A_PMUL;
              end
            end
            default: begin
              acc_d   = '0;
              state_d = sev_pkg::A_DONE;
            end
          endcase
        end
      end
      sev_pkg::A_DIV: begin
        if (!div_diff[W]) begin
          rem_d = div_diff[W-1:0];
          acc_d = {acc_q[W-2:0], 1'b1};
        end else begin
          rem_d = div_sh[W-1:0];
          acc_d = {acc_q[W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = sev_pkg::A_FIX;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      sev_pkg::A_FIX: begin
        acc_d   = neg_q ? (W'(0) - acc_q) : acc_q;
        state_d = sev_pkg::A_DONE;
      end
      sev_pkg::A_PMUL: begin
        if (exp_q[0]) begin
          acc_d = prod;
        end
        exp_d = exp_q >> 1;
        if (exp_q[W-2:1] == '0) begin
          state_d = sev_pkg::A_DONE;
        end else begin
          state_d = sev_pkg::A_PSQ;
        end
      end
      sev_pkg::A_PSQ: begin
        mul_a   = aux_q;
        mul_b   = aux_q;
        aux_d   = prod;
        state_d = sev_pkg::A_PMUL;
      end
      sev_pkg::A_DONE: begin
        state_d = sev_pkg::A_IDLE;
      end
      default: begin
        state_d = sev_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sev_pkg::A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    aux_q  <= aux_d;
    rem_q  <= rem_d;
    exp_q  <= exp_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    divz_q <= divz_d;
  end

  assign rsp_o.done     = (state_q == sev_pkg::A_DONE);
  assign rsp_o.div_zero = divz_q;
  assign result_o       = acc_q;

endmodule

`default_nettype wire

FILE: bench/tb_stack_expression_evaluator_unit.sv
// Self-checking testbench for the stack expression evaluator: directed edge cases plus random traffic.
`timescale 1ns / 1ps

module tb_stack_expression_evaluator_unit;

  localparam int unsigned DATA_W      = sev_pkg::DATA_W;
  localparam int unsigned CODE_W      = sev_pkg::CODE_W;
  localparam int unsigned DEPTH_W     = sev_pkg::DEPTH_W;
  localparam int unsigned STATUS_W    = sev_pkg::STATUS_W;
  localparam int unsigned STACK_DEPTH = sev_pkg::STACK_DEPTH;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_APPLY = 1'b1;
  // codes above OP_POW drop two entries
  localparam logic [CODE_W-1:0] OP_DROP_LO  = 3'd5;
  localparam logic [CODE_W-1:0] OP_DROP_MID = 3'd6;
  localparam logic [CODE_W-1:0] OP_DROP_HI  = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam int unsigned CYCLE_LIMIT  = 800000;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic [DEPTH_W-1:0]       depth;
    sev_pkg::status_e         status;
  } outcome_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       in_valid_i      = 1'b0;
  logic                       in_ready_o;
  logic                       mode_i          = MODE_PUSH;
  logic signed [DATA_W-1:0]   operand_value_i = '0;
  logic [CODE_W-1:0]          operator_code_i = sev_pkg::OP_ADD;
  logic                       out_valid_o;
  logic                       out_ready_i     = 1'b0;
  logic signed [DATA_W-1:0]   top_value_o;
  logic [DEPTH_W-1:0]         depth_o;
  logic [STATUS_W-1:0]        status_o;

  // calculator shadow state
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned       calc_count = 0;

  outcome_t    pending_outcomes[$];
  int unsigned mismatch_cnt  = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b1;
  bit          rx_always     = 1'b0;
  int unsigned hold_off_left = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_style      = 0;
  int unsigned rx_pat_cnt    = 0;

  stack_expression_evaluator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .operand_value_i(operand_value_i),
    .operator_code_i(operator_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_value_o    (top_value_o),
    .depth_o        (depth_o),
    .status_o       (status_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DATA_W-1:0] power_word(logic [DATA_W-1:0] base,
                                                   logic [DATA_W-1:0] expo);
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] sq;
    acc = 1;
    sq  = base;
    // negative exponent: only unit bases survive
    if (expo[DATA_W-1]) begin
      if (base == 1) return 1;
      if (base == '1) return expo[0] ? '1 : 1;
      return '0;
    end
    for (int i = 0; i < DATA_W - 1; i++) begin
      if (expo[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  function automatic logic [DATA_W-1:0] quotient_word(logic [DATA_W-1:0] num,
                                                      logic [DATA_W-1:0] den);
    logic [DATA_W-1:0] mag_n;
    logic [DATA_W-1:0] mag_d;
    logic [DATA_W-1:0] q;
    mag_n = num[DATA_W-1] ? -num : num;
    mag_d = den[DATA_W-1] ? -den : den;
    q     = mag_n / mag_d;
    return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
  endfunction

  function automatic outcome_t apply_word(logic m, logic [DATA_W-1:0] v, logic [CODE_W-1:0] c);
    outcome_t          res;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    logic [DATA_W-1:0] val;
    logic              keep;
    res.status = sev_pkg::ST_OK;
    if (m == MODE_PUSH) begin
      if (calc_count >= STACK_DEPTH) begin
        res.status = sev_pkg::ST_FULL;
      end else begin
        calc_stack[calc_count] = v;
        calc_count++;
      end
    end else if (calc_count < 2) begin
      res.status = sev_pkg::ST_UNDER;
    end else begin
      lhs  = calc_stack[calc_count-1];
      rhs  = calc_stack[calc_count-2];
      calc_count -= 2;
      keep = 1'b1;
      val  = '0;
      case (c)
        sev_pkg::OP_ADD: val = lhs + rhs;
        sev_pkg::OP_SUB: val = lhs - rhs;
        sev_pkg::OP_DIV: begin
          if (rhs == '0) res.status = sev_pkg::ST_DIVZ;
          else val = quotient_word(lhs, rhs);
        end
        sev_pkg::OP_MUL: val = lhs * rhs;
        sev_pkg::OP_POW: val = power_word(lhs, rhs);
        default: keep = 1'b0;
      endcase
      if (keep) begin
        calc_stack[calc_count] = val;
        calc_count++;
      end
    end
    res.top   = (calc_count > 0) ? calc_stack[calc_count-1] : '0;
    res.depth = DEPTH_W'(calc_count);
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 1;
      2: return '1;
      3: return WORD_MIN;
      4: return WORD_MAX;
      5, 6: return DATA_W'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word, wait for it to be taken, then record what it should produce.
  task automatic send_word(input logic m, input logic [DATA_W-1:0] v,
                           input logic [CODE_W-1:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = 0;
      if (gaps_on)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    mode_i          <= m;
    operand_value_i <= v;
    operator_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(apply_word(m, v, c));
  endtask

  task automatic push_value(input logic [DATA_W-1:0] v);
    send_word(MODE_PUSH, v, CODE_W'($urandom));
  endtask

  task automatic apply_op(input logic [CODE_W-1:0] c);
    send_word(MODE_APPLY, $urandom, c);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_underflow();
    apply_op(sev_pkg::OP_ADD);
    push_value(5);
    apply_op(OP_DROP_HI);
  endtask

  task automatic test_arith_edges();
    push_value(1);
    push_value(WORD_MAX);
    apply_op(sev_pkg::OP_ADD);        // wraps to most negative
    push_value('1);
    push_value(WORD_MIN);
    apply_op(sev_pkg::OP_DIV);        // most negative / -1
    push_value('0);
    push_value(9);
    apply_op(sev_pkg::OP_DIV);        // divide by zero
    apply_op(OP_DROP_MID);
  endtask

  task automatic test_power_cases();
    push_value('0);
    push_value('0);
    apply_op(sev_pkg::OP_POW);        // 0 ** 0
    push_value(-3);
    push_value('1);
    apply_op(sev_pkg::OP_POW);        // -1, odd negative exponent
    push_value(-2);
    push_value(1);
    apply_op(sev_pkg::OP_POW);
    push_value('1);
    push_value(7);
    apply_op(sev_pkg::OP_POW);        // other base, negative exponent
  endtask

  task automatic test_full_stack();
    while (calc_count < STACK_DEPTH) push_value(pick_value());
    push_value(WORD_MAX);    // dropped
    apply_op(OP_DROP_LO);
  endtask

  // Mostly well-formed: pushes when shallow, operators when deep, some pure noise.
  task automatic test_random_traffic(input int unsigned n);
    logic        m;
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)
        m = $urandom_range(0, 1);
      else if (calc_count < 2)
        m = (roll < 85) ? MODE_PUSH : MODE_APPLY;
      else if (calc_count >= STACK_DEPTH)
        m = (roll < 25) ? MODE_PUSH : MODE_APPLY;
      else
        m = (roll < 55) ? MODE_PUSH : MODE_APPLY;
      if (m == MODE_PUSH) push_value(pick_value());
      else apply_op(CODE_W'($urandom_range(0, 2**CODE_W - 1)));
    end
  endtask

  // Receiver holds off long enough for the block to back up into its input.
  task automatic test_output_backpressure();
    gaps_on       = 1'b0;
    hold_off_left = 150;
    test_random_traffic(40);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_back_to_back(input int unsigned n);
    gaps_on   = 1'b0;
    rx_always = 1'b1;
    test_random_traffic(n);
    gaps_on   = 1'b1;
    rx_always = 1'b0;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    rx_pat_cnt++;
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ready_i <= 1'b0;
    end else if (rx_always) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_phase_left == 0) begin
        rx_style      = $urandom_range(0, 3);
        rx_phase_left = $urandom_range(20, 200);
      end
      rx_phase_left--;
      case (rx_style)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= ($urandom_range(0, 7) != 0);
        default: out_ready_i <= ((rx_pat_cnt % 5) < 2);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t exp_word;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected word: expected none, actual top %0d depth %0d status %0d",
                 $time, top_value_o, depth_o, status_o);
      end else begin
        exp_word = pending_outcomes.pop_front();
        if (exp_word.top !== top_value_o) begin
          mismatch_cnt++;
          $display("%0t: top_value expected %0d actual %0d", $time, exp_word.top, top_value_o);
        end
        if (exp_word.depth !== depth_o) begin
          mismatch_cnt++;
          $display("%0t: depth expected %0d actual %0d", $time, exp_word.depth, depth_o);
        end
        if (exp_word.status !== status_o) begin
          mismatch_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, exp_word.status, status_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_underflow();
    test_arith_edges();
    test_power_cases();
    test_full_stack();
    wait_drained();
    test_random_traffic(1250);
    wait_drained();
    test_output_backpressure();
    test_back_to_back(200);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/sev_pkg.sv
rtl/sev_alu.sv
rtl/stack_expression_evaluator_unit.sv
bench/tb_stack_expression_evaluator_unit.sv
